// ===== hdl/swe_pkg.sv =====
// sliding window energy: shared constants, types and register codes
// no dependencies; compiled first
package swe_pkg;

	localparam int MAX_WINDOW_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	// register file
	localparam int WL_W   = 9;
	localparam int ADDR_W = 3;
	localparam logic REG_WINDOW_LEN    = 1'b0;
	localparam logic REG_GRADIENT_MODE = 1'b1;
	localparam logic [WL_W-1:0] WINDOW_LEN_RST = 9'd15;

	// result field widths
	localparam int MS_W  = 39;
	localparam int RMS_W = 20;
	localparam int LOG_W = 16;

	// mean square saturation, ln2 in Q0.32, log rounding
	localparam logic [MS_W-1:0] MS_MAX   = 39'h3F_FFFF_FFFF;
	localparam logic [31:0]     LN2_Q32  = 32'd2977044472;
	localparam int              FRAC_BITS = 24;
	localparam logic [63:0]     RND_BIAS = 64'h1000_2000_0000_0000;
	localparam logic [17:0]     LOG_OFS  = 18'd16384;
	localparam logic [31:0]     LOG_SUB  = 32'h0800_0000;

	localparam int QUEUE_DEPTH = 2;

	// one job handed from the front to the back
	typedef struct packed {
		logic [MS_W-1:0] m;
		logic            has_val;
		logic            te;
	} q_entry_t;

endpackage

// ===== hdl/swe_if.sv =====
// sliding window energy: sample and result channel interfaces
// depends on swe_pkg
interface swe_in_if #(parameter int SAMPLE_BITS = swe_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          trace_end;

	modport source(output valid, sample, trace_end, input ready);
	modport sink(input valid, sample, trace_end, output ready);
endinterface

interface swe_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [swe_pkg::MS_W-1:0]     mean_square;
	logic signed [swe_pkg::RMS_W-1:0]    rms;
	logic signed [swe_pkg::LOG_W-1:0]    log_energy;
	logic                                log_valid;
	logic                                grad_valid;
	logic                                trace_last;
	logic                                run_last;

	modport source(output valid, mean_square, rms, log_energy, log_valid, grad_valid,
		trace_last, run_last, input ready);
	modport sink(input valid, mean_square, rms, log_energy, log_valid, grad_valid,
		trace_last, run_last, output ready);
endinterface

// ===== hdl/swe_front.sv =====
// sliding window energy front: window store, running square sum, mean square divider
// depends on swe_pkg and swe_if
module swe_front #(
	parameter int MAX_WINDOW  = swe_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swe_pkg::SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	swe_in_if.sink                     samples,
	input  logic [swe_pkg::WL_W-1:0]   window_len,
	input  logic                       restart,
	output logic                       push,
	output swe_pkg::q_entry_t          push_entry,
	input  logic                       q_full
);
	import swe_pkg::*;

	localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int PW    = LEN_W + 1;
	localparam int SUM_W = 2 * SAMPLE_BITS - 1 + $clog2(MAX_WINDOW);
	localparam int DW    = SUM_W + 8;
	localparam int CNT_W = $clog2(DW + 1);
	localparam int CW    = (DW > MS_W) ? DW : MS_W;

	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_SQ   = 5'b00010,
		F_SUM  = 5'b00100,
		F_DIV  = 5'b01000,
		F_PUSH = 5'b10000
	} f_state_t;

	f_state_t               state_q;
	logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
	logic [AW-1:0]          wr_q;
	logic [LEN_W-1:0]       fill_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] rd_q;
	logic                   te_q;
	logic                   full_q;
	logic                   has_val_q;
	logic [SUM_W-1:0]       sq_new_q;
	logic [SUM_W-1:0]       sq_old_q;
	logic [SUM_W-1:0]       sum_q;
	logic [LEN_W-1:0]       rem_q;
	logic [DW-1:0]          dq_q;
	logic [CNT_W-1:0]       cnt_q;

	logic [LEN_W-1:0]       len;
	logic [PW-1:0]          rd_diff;
	logic [AW-1:0]          rd_addr;
	logic                   acc;
	logic [SUM_W-1:0]       new_sum;
	logic [PW-1:0]          trial;
	logic [CW-1:0]          q_ext;

	function automatic logic [SAMPLE_BITS-1:0] mag(input logic [SAMPLE_BITS-1:0] s);
		return s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
	endfunction

	// effective window length
	always_comb begin
		if (window_len == '0) begin
			len = LEN_W'(1);
		end else if (32'(window_len) > MAX_WINDOW) begin
			len = LEN_W'(MAX_WINDOW);
		end else begin
			len = LEN_W'(window_len);
		end
	end

	// address of the sample leaving the window
	always_comb begin
		rd_diff = PW'(wr_q) - PW'(len);
		if (rd_diff[PW-1]) begin
			rd_diff = rd_diff + PW'(MAX_WINDOW);
		end
		rd_addr = rd_diff[AW-1:0];
	end

	assign samples.ready = (state_q == F_IDLE);
	assign acc           = samples.valid && samples.ready;
	assign new_sum       = sum_q - sq_old_q + sq_new_q;
	assign trial         = {rem_q, dq_q[DW-1]} - {1'b0, len};
	assign q_ext         = CW'(dq_q);

	// window store, read before write
	always_ff @(posedge clk) begin
		if (acc) begin
			mem[wr_q] <= samples.sample;
			rd_q      <= mem[rd_addr];
		end
	end

	// sequencer and arithmetic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			wr_q    <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
		end else if (restart) begin
			state_q <= F_IDLE;
			wr_q    <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (acc) begin
						sample_q <= samples.sample;
						te_q     <= samples.trace_end;
						full_q   <= (fill_q >= len);
						if (fill_q < len) begin
							fill_q <= fill_q + 1'b1;
						end
						wr_q    <= (wr_q == AW'(MAX_WINDOW - 1)) ? '0 : wr_q + 1'b1;
						state_q <= F_SQ;
					end
				end
				F_SQ: begin
					sq_new_q <= SUM_W'(mag(sample_q) * mag(sample_q));
					sq_old_q <= full_q ? SUM_W'(mag(rd_q) * mag(rd_q)) : '0;
					state_q  <= F_SUM;
				end
				F_SUM: begin
					has_val_q <= (fill_q >= len);
					rem_q     <= '0;
					dq_q      <= {new_sum, 8'b0};
					cnt_q     <= CNT_W'(DW);
					sum_q     <= te_q ? '0 : new_sum;
					if (te_q) begin
						fill_q <= '0;
						wr_q   <= '0;
					end
					if (fill_q >= len) begin
						state_q <= F_DIV;
					end else if (te_q) begin
						state_q <= F_PUSH;
					end else begin
						state_q <= F_IDLE;
					end
				end
				F_DIV: begin
					// one quotient bit per cycle
					if (!trial[PW-1]) begin
						rem_q <= trial[LEN_W-1:0];
					end else begin
						rem_q <= {rem_q[LEN_W-2:0], dq_q[DW-1]};
					end
					dq_q  <= {dq_q[DW-2:0], ~trial[PW-1]};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// job toward the back
	assign push               = (state_q == F_PUSH) && !q_full;
	assign push_entry.m       = (q_ext > CW'(MS_MAX)) ? MS_MAX : q_ext[MS_W-1:0];
	assign push_entry.has_val = has_val_q;
	assign push_entry.te      = te_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len) else $error("fill count beyond window length");
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !restart |=> state_q == F_SQ) else $error("accepted sample not squared");
	a_push_job: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_entry.has_val || push_entry.te) else $error("empty job pushed");
`endif

endmodule

// ===== hdl/swe_queue.sv =====
// sliding window energy: short job queue between front and back
// depends on swe_pkg
module swe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  swe_pkg::q_entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output swe_pkg::q_entry_t pop_entry
);
	import swe_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t         slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid     = (count_q != '0);
	assign pop_entry = slot_q[rp_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_entry;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid) else $error("queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ===== hdl/swe_back.sv =====
// sliding window energy back: square root, log unit, gradient history, output register
// depends on swe_pkg and swe_if
module swe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              gradient_mode,
	input  logic              restart,
	input  logic              q_valid,
	input  swe_pkg::q_entry_t q_entry,
	output logic              pop,
	swe_out_if.source         results
);
	import swe_pkg::*;

	typedef enum logic [8:0] {
		B_IDLE = 9'b000000001,
		B_SQRT = 9'b000000010,
		B_NORM = 9'b000000100,
		B_MUL  = 9'b000001000,
		B_ACC  = 9'b000010000,
		B_LN   = 9'b000100000,
		B_RND  = 9'b001000000,
		B_OUT1 = 9'b010000000,
		B_OUT2 = 9'b100000000
	} b_state_t;

	b_state_t                 state_q;
	logic                     te_q;
	logic [MS_W-1:0]          m_q;
	logic [MS_W-1:0]          nm_q;
	logic [5:0]               e_q;
	logic [RMS_W-1:0]         rms_q;
	logic [RMS_W-1:0]         sbit_q;
	logic [31:0]              y_q;
	logic [63:0]              prod_q;
	logic [FRAC_BITS-1:0]     frac_q;
	logic [4:0]               cnt_q;
	logic [63:0]              p_q;
	logic signed [LOG_W-1:0]  lg_q;
	logic                     lv_q;

	// history: slot 0 older, slot 1 centre
	logic [MS_W-1:0]          ms0_q, ms1_q;
	logic [RMS_W-1:0]         rms0_q, rms1_q;
	logic signed [LOG_W-1:0]  lg0_q, lg1_q;
	logic                     lok0_q, lok1_q;
	logic [1:0]               hc_q;

	logic                     can_load;
	logic                     out_load;
	logic [RMS_W-1:0]         trial;
	logic [2*RMS_W-1:0]       trial_sq;
	logic [32:0]              ys;
	logic signed [31:0]       t_val;
	logic [63:0]              rnd_sum;
	logic [17:0]              lg_full;
	logic                     np, pp, need1, need2;
	logic [MS_W-1:0]          n_ms;
	logic [RMS_W-1:0]         n_rms;
	logic signed [LOG_W-1:0]  n_lg;
	logic                     n_lv;
	logic signed [40:0]       g_ms, g_rms, g_lg;
	logic                     g_lok;

	function automatic logic signed [40:0] gdiff(input logic signed [40:0] c,
		input logic signed [40:0] p, input logic signed [40:0] n,
		input logic pv, input logic nv);
		logic signed [40:0] d;
		if (pv && nv) begin
			d = (n - p) >>> 1;
		end else if (nv) begin
			d = n - c;
		end else if (pv) begin
			d = c - p;
		end else begin
			d = '0;
		end
		return d;
	endfunction

	assign can_load = !results.valid || results.ready;
	assign out_load = can_load && (((state_q == B_OUT1) && need1) ||
		((state_q == B_OUT2) && need2));
	assign pop      = (state_q == B_IDLE) && q_valid;
	assign trial    = rms_q | sbit_q;
	assign trial_sq = trial * trial;
	assign ys       = prod_q[63:31];
	assign t_val    = $signed({2'b0, e_q, frac_q}) - $signed(LOG_SUB);
	assign rnd_sum  = p_q + RND_BIAS;
	assign lg_full  = rnd_sum[63:46] - LOG_OFS;

	// gradient of the centre value
	always_comb begin
		np    = (state_q == B_OUT1);
		pp    = (hc_q == 2'd2);
		n_ms  = np ? m_q : '0;
		n_rms = np ? rms_q : '0;
		n_lg  = np ? lg_q : '0;
		n_lv  = np && lv_q;
		g_ms  = gdiff(41'(ms1_q), 41'(ms0_q), 41'(n_ms), pp, np);
		g_rms = gdiff(41'(rms1_q), 41'(rms0_q), 41'(n_rms), pp, np);
		g_lok = lok1_q && ((pp && lok0_q) || n_lv);
		g_lg  = g_lok ? gdiff(41'(lg1_q), 41'(lg0_q), 41'(n_lg), pp && lok0_q, n_lv) : '0;
		need1 = !gradient_mode || (hc_q != 2'd0);
		need2 = gradient_mode && (hc_q != 2'd0);
	end

	// sequencer, root and log units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			hc_q    <= '0;
			lok0_q  <= 1'b0;
			lok1_q  <= 1'b0;
			results.valid <= 1'b0;
		end else begin
			if (out_load) begin
				results.valid <= 1'b1;
			end else if (results.valid && results.ready) begin
				results.valid <= 1'b0;
			end
			if (restart) begin
				hc_q   <= '0;
				lok0_q <= 1'b0;
				lok1_q <= 1'b0;
				ms0_q  <= '0;
				ms1_q  <= '0;
				rms0_q <= '0;
				rms1_q <= '0;
				lg0_q  <= '0;
				lg1_q  <= '0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						te_q   <= q_entry.te;
						m_q    <= q_entry.m;
						nm_q   <= q_entry.m;
						e_q    <= 6'(MS_W - 1);
						rms_q  <= '0;
						sbit_q <= {1'b1, {(RMS_W-1){1'b0}}};
						state_q <= q_entry.has_val ? B_SQRT : B_OUT2;
					end
				end
				B_SQRT: begin
					// one root bit per cycle
					if (trial_sq <= {1'b0, m_q}) begin
						rms_q <= trial;
					end
					sbit_q <= sbit_q >> 1;
					if (sbit_q[0]) begin
						lv_q <= (m_q != '0);
						lg_q <= '0;
						state_q <= (m_q != '0) ? B_NORM : B_OUT1;
					end
				end
				B_NORM: begin
					// leading one search, one bit per cycle
					if (nm_q[MS_W-1]) begin
						y_q    <= nm_q[MS_W-1 -: 32];
						frac_q <= '0;
						cnt_q  <= '0;
						state_q <= B_MUL;
					end else begin
						nm_q <= nm_q << 1;
						e_q  <= e_q - 1'b1;
					end
				end
				B_MUL: begin
					prod_q  <= y_q * y_q;
					state_q <= B_ACC;
				end
				B_ACC: begin
					if (ys[32]) begin
						y_q    <= ys[32:1];
						frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
					end else begin
						y_q    <= ys[31:0];
						frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
					end
					cnt_q   <= cnt_q + 1'b1;
					state_q <= (cnt_q == 5'(FRAC_BITS - 1)) ? B_LN : B_MUL;
				end
				B_LN: begin
					p_q     <= 64'(t_val * $signed({1'b0, LN2_Q32}));
					state_q <= B_RND;
				end
				B_RND: begin
					lg_q    <= lg_full[LOG_W-1:0];
					state_q <= B_OUT1;
				end
				B_OUT1: begin
					if (!need1 || can_load) begin
						if (need1) begin
							if (!gradient_mode) begin
								results.mean_square <= m_q;
								results.rms         <= rms_q;
								results.log_energy  <= lg_q;
								results.log_valid   <= lv_q;
								results.grad_valid  <= 1'b1;
								results.trace_last  <= te_q;
								results.run_last    <= 1'b1;
							end else begin
								results.mean_square <= g_ms[MS_W-1:0];
								results.rms         <= g_rms[RMS_W-1:0];
								results.log_energy  <= g_lg[LOG_W-1:0];
								results.log_valid   <= g_lok;
								results.grad_valid  <= 1'b1;
								results.trace_last  <= 1'b0;
								results.run_last    <= !te_q;
							end
						end
						if (gradient_mode) begin
							// shift the history
							ms0_q  <= ms1_q;
							rms0_q <= rms1_q;
							lg0_q  <= lg1_q;
							lok0_q <= lok1_q;
							ms1_q  <= m_q;
							rms1_q <= rms_q;
							lg1_q  <= lg_q;
							lok1_q <= lv_q;
							hc_q   <= (hc_q != 2'd0) ? 2'd2 : 2'd1;
						end
						state_q <= te_q ? B_OUT2 : B_IDLE;
					end
				end
				B_OUT2: begin
					if (!need2 || can_load) begin
						if (need2) begin
							results.mean_square <= g_ms[MS_W-1:0];
							results.rms         <= g_rms[RMS_W-1:0];
							results.log_energy  <= g_lg[LOG_W-1:0];
							results.log_valid   <= g_lok;
							results.grad_valid  <= pp;
							results.trace_last  <= 1'b1;
							results.run_last    <= 1'b1;
						end
						// end of trace clears the history
						hc_q   <= '0;
						lok0_q <= 1'b0;
						lok1_q <= 1'b0;
						ms0_q  <= '0;
						ms1_q  <= '0;
						rms0_q <= '0;
						rms1_q <= '0;
						lg0_q  <= '0;
						lg1_q  <= '0;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_hc_range: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q != 2'd3) else $error("history count out of range");
	a_out2_te: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_OUT2 |-> te_q) else $error("trace end stage without trace end");
	a_centre_log: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q == 2'd0 |-> !lok1_q && !lok0_q) else $error("log history valid when empty");
`endif

endmodule

// ===== hdl/sliding_window_energy.sv =====
// path: from sample accept the front runs the square, sum and divider states (one quotient bit a cycle)
// and pushes the job to the queue; the back then pops it and skips the log unit for zero energy
// flow: the front takes no new sample until it is through with the last one; a back job's length
// depends on the leading one search and the 24-step log squaring loop; the queue lets the front run ahead
// reset: asynchronous, window_len 15, gradient_mode 0, sums and history cleared
module sliding_window_energy #(
	parameter int MAX_WINDOW  = swe_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swe_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	swe_in_if.sink                      samples,
	swe_out_if.source                   results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swe_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import swe_pkg::*;

	logic [WL_W-1:0] window_len_q;
	logic            gradient_mode_q;
	logic            wr_en;
	logic            push, q_full, pop, q_valid;
	q_entry_t        push_entry, pop_entry;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register writes; any write restarts the trace
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q    <= WINDOW_LEN_RST;
			gradient_mode_q <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_WINDOW_LEN:    window_len_q    <= pwdata[WL_W-1:0];
				REG_GRADIENT_MODE: gradient_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		unique case (paddr[2])
			REG_WINDOW_LEN:    prdata = {{(32-WL_W){1'b0}}, window_len_q};
			REG_GRADIENT_MODE: prdata = {31'b0, gradient_mode_q};
			default:           prdata = '0;
		endcase
	end

	swe_front #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.window_len (window_len_q),
		.restart    (wr_en),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	swe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.valid      (q_valid),
		.pop_entry  (pop_entry)
	);

	swe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.gradient_mode (gradient_mode_q),
		.restart       (wr_en),
		.q_valid       (q_valid),
		.q_entry       (pop_entry),
		.pop           (pop),
		.results       (results)
	);

endmodule

// ===== sim/swe_energy_checker.sv =====
// sliding window energy: result checker with its own energy predictor
// depends on swe_pkg and the swe_in_if / swe_out_if interfaces
module swe_energy_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	swe_in_if                          in_ch,
	swe_out_if                         out_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [swe_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output int                         fail_count,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import swe_pkg::*;

	localparam logic [ADDR_W-1:0] ADDR_WINDOW_LEN    = {REG_WINDOW_LEN, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_GRADIENT_MODE = {REG_GRADIENT_MODE, 2'b00};
	localparam int DEPTH = MAX_WINDOW_DEF;

	typedef struct {
		logic [MS_W-1:0]  ms;
		logic [RMS_W-1:0] rms;
		logic [LOG_W-1:0] lg;
		logic             lv;
		logic             gv;
		logic             tl;
		logic             rl;
	} energy_res_t;

	energy_res_t energy_expected[$];

	// predictor state
	logic [15:0]        win_samples[DEPTH];
	longint unsigned    sq_sum;
	int                 fill;
	int                 wr_idx;
	longint             ms_hist[2];
	longint             rms_hist[2];
	longint             log_hist[2];
	bit                 log_hist_ok[2];
	int                 hist_cnt;
	logic [WL_W-1:0]    win_len_reg;
	bit                 grad_mode;

	function automatic longint unsigned square_mag(logic [15:0] raw);
		longint mag;
		mag = longint'($signed(raw));
		if (mag < 0) mag = -mag;
		return longint'(mag * mag);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// log2 by mantissa squaring, scaled by ln2, rounded to q10
	function automatic longint ln_q10(longint unsigned m);
		int e;
		longint unsigned y, frac, u;
		longint t, p;
		e = 63;
		while (((m >> e) & 64'd1) == 0) e--;
		y = (e >= 31) ? (m >> (e - 31)) : (m << (31 - e));
		frac = 0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			y = (y * y) >> 31;
			frac <<= 1;
			if (y >= 64'h1_0000_0000) begin
				y >>= 1;
				frac |= 1;
			end
		end
		t = longint'((longint'(e) << FRAC_BITS) + frac) - (longint'(8) << FRAC_BITS);
		p = t * longint'(LN2_Q32);
		u = longint'(p) + RND_BIAS;
		return longint'(u >> 46) - 16384;
	endfunction

	function automatic bit slope(longint cur, longint prv, longint nxt, bit pp, bit np,
		output longint g);
		if (pp && np) g = (nxt - prv) >>> 1;
		else if (np) g = nxt - cur;
		else if (pp) g = cur - prv;
		else begin
			g = 0;
			return 0;
		end
		return 1;
	endfunction

	function automatic void clear_trace();
		sq_sum = 0;
		fill = 0;
		wr_idx = 0;
		hist_cnt = 0;
		ms_hist = '{0, 0};
		rms_hist = '{0, 0};
		log_hist = '{0, 0};
		log_hist_ok = '{0, 0};
	endfunction

	// gradient of the centre value held in slot 1
	function automatic void push_gradient(bit pp, bit np, longint nms, longint nrms,
		longint nlg, bit nlv, bit tl);
		energy_res_t r;
		longint gms, grms, glg;
		bit gv, lv;
		glg = 0;
		lv = 0;
		gv = slope(ms_hist[1], ms_hist[0], nms, pp, np, gms);
		void'(slope(rms_hist[1], rms_hist[0], nrms, pp, np, grms));
		if (log_hist_ok[1])
			lv = slope(log_hist[1], log_hist[0], nlg, pp && log_hist_ok[0], np && nlv, glg);
		if (!lv) glg = 0;
		r.ms = gms[MS_W-1:0];
		r.rms = grms[RMS_W-1:0];
		r.lg = glg[LOG_W-1:0];
		r.lv = lv;
		r.gv = gv;
		r.tl = tl;
		r.rl = 0;
		energy_expected.push_back(r);
	endfunction

	function automatic void energy_step(logic [15:0] raw, bit te);
		int len, n0;
		longint unsigned m;
		longint ms, rms, lg;
		bit lv;
		energy_res_t r;
		len = (win_len_reg == 0) ? 1 : (win_len_reg > DEPTH ? DEPTH : int'(win_len_reg));
		n0 = energy_expected.size();
		if (fill >= len) sq_sum -= square_mag(win_samples[(wr_idx + DEPTH - len) % DEPTH]);
		else fill++;
		win_samples[wr_idx] = raw;
		wr_idx = (wr_idx + 1) % DEPTH;
		sq_sum += square_mag(raw);

		if (fill >= len) begin
			m = (sq_sum << 8) / longint'(len);
			if (m > longint'(MS_MAX)) m = longint'(MS_MAX);
			lv = (m != 0);
			ms = longint'(m);
			rms = longint'(int_sqrt(m));
			lg = lv ? ln_q10(m) : 0;
			if (!grad_mode) begin
				r.ms = ms[MS_W-1:0];
				r.rms = rms[RMS_W-1:0];
				r.lg = lg[LOG_W-1:0];
				r.lv = lv;
				r.gv = 1;
				r.tl = te;
				r.rl = 0;
				energy_expected.push_back(r);
			end else begin
				if (hist_cnt != 0) begin
					push_gradient(hist_cnt == 2, 1, ms, rms, lg, lv, 0);
					ms_hist[0] = ms_hist[1];
					rms_hist[0] = rms_hist[1];
					log_hist[0] = log_hist[1];
					log_hist_ok[0] = log_hist_ok[1];
					hist_cnt = 2;
				end else begin
					hist_cnt = 1;
				end
				ms_hist[1] = ms;
				rms_hist[1] = rms;
				log_hist[1] = lg;
				log_hist_ok[1] = lv;
			end
		end

		if (te && grad_mode && hist_cnt != 0) push_gradient(hist_cnt == 2, 0, 0, 0, 0, 0, 1);
		if (energy_expected.size() > n0) energy_expected[energy_expected.size()-1].rl = 1;
		if (te) clear_trace();
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t result mismatch on %s: got %0h expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	// watch configuration writes, results and requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_reg = WINDOW_LEN_RST;
			grad_mode = 0;
			clear_trace();
			energy_expected.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr == ADDR_WINDOW_LEN) begin
					win_len_reg = pwdata[WL_W-1:0];
					clear_trace();
				end else if (paddr == ADDR_GRADIENT_MODE) begin
					grad_mode = pwdata[0];
					clear_trace();
				end
			end
			if (out_ch.valid && out_ch.ready) begin
				if (energy_expected.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					energy_res_t e;
					e = energy_expected.pop_front();
					if (out_ch.mean_square !== e.ms)
						report_mismatch("mean_square", out_ch.mean_square, e.ms);
					if (out_ch.rms !== e.rms) report_mismatch("rms", out_ch.rms, e.rms);
					if (out_ch.log_energy !== e.lg)
						report_mismatch("log_energy", out_ch.log_energy, e.lg);
					if (out_ch.log_valid !== e.lv)
						report_mismatch("log_valid", out_ch.log_valid, e.lv);
					if (out_ch.grad_valid !== e.gv)
						report_mismatch("grad_valid", out_ch.grad_valid, e.gv);
					if (out_ch.trace_last !== e.tl)
						report_mismatch("trace_last", out_ch.trace_last, e.tl);
					if (out_ch.run_last !== e.rl)
						report_mismatch("run_last", out_ch.run_last, e.rl);
				end
			end
			if (in_ch.valid && in_ch.ready) energy_step(in_ch.sample, in_ch.trace_end);
		end
		pending = energy_expected.size();
	end

endmodule

// ===== sim/tb_sliding_window_energy.sv =====
// sliding window energy: testbench top, sample stimulus, register writes and verdict
// depends on swe_pkg, swe_if.sv, swe_energy_checker and the block itself
module tb_sliding_window_energy;
	timeunit 1ns;
	timeprecision 1ps;
	import swe_pkg::*;

	localparam logic [ADDR_W-1:0] ADDR_WINDOW_LEN    = {REG_WINDOW_LEN, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_GRADIENT_MODE = {REG_GRADIENT_MODE, 2'b00};
	localparam int RANDOM_ITEMS  = 1900;
	localparam int SETTLE_CYCLES = 300;
	localparam int STALL_LIMIT   = 20000;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	int                fail_count, pending;
	int                idle_pct = 0, stall_pct = 0;
	int                sent = 0, quiet = 0;

	swe_in_if  in_ch();
	swe_out_if out_ch();

	sliding_window_energy dut (
		.clk(clk), .arst_n(arst_n), .samples(in_ch.sink), .results(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	swe_energy_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .fail_count(fail_count), .pending(pending)
	);

	always #10 clk = ~clk;

	// result receiver with random stalls
	initial out_ch.ready = 0;
	always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

	// watchdog on cycles with no request, result or write accepted
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || penable)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("tb_sliding_window_energy NOT OK");
			$finish;
		end
	end

	task automatic reg_write(logic [ADDR_W-1:0] a, logic [31:0] d);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1; paddr = a; pwdata = d;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	// drain results and the pipeline, then set both registers
	task automatic set_mode(int wlen, bit grad);
		in_ch.valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		reg_write(ADDR_WINDOW_LEN, wlen);
		reg_write(ADDR_GRADIENT_MODE, grad);
	endtask

	task automatic send_sample(logic [15:0] s, bit te);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid = 0;
			@(negedge clk);
		end
		in_ch.valid = 1;
		in_ch.sample = s;
		in_ch.trace_end = te;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	function automatic logic [15:0] pick_sample(int style);
		case (style)
			0: return 16'($urandom);
			1: return ($urandom_range(7) == 0) ? 16'($signed($urandom_range(32)) - 16) : 16'd0;
			2: return ($urandom_range(1) == 0) ? 16'h8000 : 16'h7fff;
			default: return 16'($signed($urandom_range(512)) - 256);
		endcase
	endfunction

	initial begin
		int wlen, eff, tlen, style, setting;
		bit grad;
		in_ch.valid = 0;
		in_ch.sample = '0;
		in_ch.trace_end = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;

		// window of one: zero energy, full scale, saturation, small values
		set_mode(1, 0);
		send_sample(16'd0, 0);
		send_sample(16'h7fff, 0);
		send_sample(16'h8000, 0);
		send_sample(16'd1, 0);
		send_sample(16'hffff, 1);
		// gradients: single value trace, invalid log neighbours, two-value trace
		set_mode(1, 1);
		send_sample(16'd100, 1);
		send_sample(16'd0, 0);
		send_sample(16'd5, 0);
		send_sample(16'd0, 0);
		send_sample(16'h8000, 0);
		send_sample(16'd0, 1);
		send_sample(16'd3, 0);
		send_sample(16'h7fff, 1);
		// trace shorter than the window, then a full one
		set_mode(3, 1);
		send_sample(16'd7, 0);
		send_sample(16'd9, 1);
		send_sample(16'h8000, 0);
		send_sample(16'h8000, 0);
		send_sample(16'h8000, 0);
		send_sample(16'd2, 1);
		// length zero acts as one, at the reset mode
		set_mode(0, 0);
		send_sample(16'd4, 0);
		send_sample(16'd0, 1);

		sent = 0;
		setting = 0;
		while (sent < RANDOM_ITEMS) begin
			case (setting % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 47; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 47; end
				default: begin idle_pct = 34; stall_pct = 34; end
			endcase
			case ($urandom_range(99)) inside
				[0:69]:  wlen = $urandom_range(1, 12);
				[70:86]: wlen = $urandom_range(13, 40);
				[87:92]: wlen = $urandom_range(0, 1);
				[93:96]: wlen = $urandom_range(200, 256);
				default: wlen = (setting % 2) ? 511 : $urandom_range(257, 510);
			endcase
			grad = $urandom_range(1);
			set_mode(wlen, grad);
			eff = (wlen == 0) ? 1 : (wlen > 256 ? 256 : wlen);
			for (int k = 0; k < ((eff > 40) ? 1 : 4); k++) begin
				tlen = ($urandom_range(9) == 0) ? $urandom_range(1, eff)
					: eff + $urandom_range(0, 15);
				style = $urandom_range(3);
				for (int j = 0; j < tlen; j++) begin
					// hold the sender until every result so far is out
					if (setting % 7 == 3 && k == 0 && j == tlen / 2) begin
						in_ch.valid = 0;
						while (pending != 0) @(negedge clk);
					end
					send_sample(pick_sample(style), j == tlen - 1);
				end
			end
			setting++;
		end
		in_ch.valid = 0;

		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_sliding_window_energy OK");
		end else begin
			$display("tb_sliding_window_energy NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/swe_pkg.sv
hdl/swe_if.sv
hdl/swe_front.sv
hdl/swe_queue.sv
hdl/swe_back.sv
hdl/sliding_window_energy.sv
sim/swe_energy_checker.sv
sim/tb_sliding_window_energy.sv
